>>> rtl/psrb_pkg.sv
// Shared types, codes and decode helpers for the PSR transfer and banking unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package psrb_pkg;

  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  localparam logic [31:0] CPSR_RESET = 32'h0000_00D3;
  localparam logic [31:0] THUMB_BIT  = 32'h0000_0020;
  localparam logic [31:0] MASK_LEGAL = 32'hF000_00FF;
  localparam logic [31:0] MASK_FLAGS = 32'hF000_0000;

  localparam int          NBANK     = 22;
  localparam logic [2:0]  NO_SLOT   = 3'd7;
  localparam logic [2:0]  SWAP_LAST = 3'd6;
  localparam logic [3:0]  REG_PC    = 4'd15;

  typedef enum logic [2:0] {
    REQ_READ    = 3'd0,
    REQ_WRITE   = 3'd1,
    REQ_MRS     = 3'd2,
    REQ_MSR_REG = 3'd3,
    REQ_MSR_IMM = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PC_OPND = 2'd1,
    ST_NO_SPSR = 2'd2,
    ST_BAD_MODE = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWAP,
    S_OUT
  } fsm_t;

  typedef struct packed {
    logic       load;
    logic       exec;
    logic       swap;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic need_swap;
  } sts_t;

  function automatic logic mode_ok(input logic [4:0] m);
    return m == MODE_USR || m == MODE_FIQ || m == MODE_IRQ || m == MODE_SVC ||
           m == MODE_ABT || m == MODE_UND || m == MODE_SYS;
  endfunction

  function automatic logic [2:0] spsr_slot(input logic [4:0] m);
    logic [2:0] s;
    unique case (m)
      MODE_FIQ: s = 3'd0;
      MODE_IRQ: s = 3'd1;
      MODE_SVC: s = 3'd2;
      MODE_ABT: s = 3'd3;
      MODE_UND: s = 3'd4;
      default:  s = NO_SLOT;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] pair_slot(input logic [4:0] m);
    logic [2:0] p;
    unique case (m)
      MODE_IRQ: p = 3'd1;
      MODE_SVC: p = 3'd2;
      MODE_ABT: p = 3'd3;
      MODE_UND: p = 3'd4;
      default:  p = 3'd0;
    endcase
    return p;
  endfunction

  // Bank entries: fiq r8-r14 at 0..6, shared r8-r12 at 7..11, r13/r14 pairs at 12..21.
  function automatic logic [4:0] bank_loc(input logic [4:0] m, input logic [2:0] i);
    logic [4:0] loc;
    if (m == MODE_FIQ) begin
      loc = {2'b00, i};
    end else if (i < 3'd5) begin
      loc = 5'd7 + {2'b00, i};
    end else begin
      loc = 5'd12 + {1'b0, pair_slot(m), 1'b0} + {4'b0000, i == SWAP_LAST};
    end
    return loc;
  endfunction

endpackage
`default_nettype wire

>>> rtl/arm_psr_transfer_banking_unit.sv
// Top level of the ARM PSR transfer and banking unit; joins psrb_ctrl and psrb_dp.
// A beat is taken in S_IDLE, run in S_EXEC, returned in S_OUT; a mode change adds S_SWAP.
// One request at a time: the bank swap steps through r8-r14, one register per cycle.
// A new beat is accepted only after the previous result has been taken with out_tready.
// Reset (rst_n low, synchronous) clears the register file, SPSRs, banks and results, sets CPSR to 0xD3.
`default_nettype none
module arm_psr_transfer_banking_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,  // instruction[31:0], reg_index[35:32], write_data[67:36]
  input  wire logic [2:0]  in_tuser,  // req_type[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata, // read_data[31:0], cpsr_value[63:32]
  output logic [2:0]       out_tuser  // status[1:0], mode_changed[2]
);
  import psrb_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] rdata, cpsr;
  logic [1:0]  status;
  logic        chg;

  psrb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  psrb_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_req       (in_tuser),
    .in_ins       (in_tdata[31:0]),
    .in_ridx      (in_tdata[35:32]),
    .in_wdat      (in_tdata[67:36]),
    .read_data    (rdata),
    .cpsr_value   (cpsr),
    .status       (status),
    .mode_changed (chg)
  );

  assign out_tdata = {cpsr, rdata};
  assign out_tuser = {chg, status};

endmodule
`default_nettype wire

>>> rtl/psrb_ctrl.sv
// Sequencing state machine for the PSR transfer and banking unit.
// Depends on psrb_pkg; drives the datapath through cmd_t and reads sts_t.
`default_nettype none
module psrb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output psrb_pkg::cmd_t      cmd,
  input  wire psrb_pkg::sts_t sts
);
  import psrb_pkg::*;

  fsm_t       state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    cmd.idx    = idx_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        idx_nxt  = '0;
        state_nxt = sts.need_swap ? S_SWAP : S_OUT;
      end
      S_SWAP: begin
        cmd.swap = 1'b1;
        idx_nxt  = idx_r + 3'd1;
        if (idx_r == SWAP_LAST) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input taken while a result is pending");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.swap |-> cmd.idx <= SWAP_LAST) else $error("bank swap index out of range");
  a_exec_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> (cmd.swap && cmd.idx == 3'd0) || out_tvalid)
    else $error("execute not followed by swap or result");
  a_load_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec) else $error("accepted beat not executed");

endmodule
`default_nettype wire

>>> rtl/psrb_dp.sv
// Datapath of the PSR transfer and banking unit: register file, CPSR, SPSRs, banks.
// Depends on psrb_pkg; steered by psrb_ctrl through cmd_t.
`default_nettype none
module psrb_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire psrb_pkg::cmd_t cmd,
  output psrb_pkg::sts_t      sts,
  input  wire logic [2:0]     in_req,
  input  wire logic [31:0]    in_ins,
  input  wire logic [3:0]     in_ridx,
  input  wire logic [31:0]    in_wdat,
  output logic [31:0]         read_data,
  output logic [31:0]         cpsr_value,
  output logic [1:0]          status,
  output logic                mode_changed
);
  import psrb_pkg::*;

  logic [2:0]  req_r;
  logic [31:0] ins_r, wdat_r;
  logic [3:0]  ridx_r;
  logic [31:0] gr_r [16];
  logic [31:0] cpsr_r;
  logic [31:0] spsr_r [5];
  logic [31:0] bank_r [NBANK];
  logic [4:0]  old_mode_r, new_mode_r;
  logic [31:0] rdata_r;
  stat_t       st_r;
  logic        chg_r;

  logic [4:0]  cur_mode;
  logic [2:0]  slot, slot_ix;
  logic        has_slot;
  logic [3:0]  raddr, rd, rm;
  logic [31:0] rval, spsr_val, opnd, mask, cmask, nv_s, nv_c;
  logic [63:0] rot_w;
  logic [3:0]  fm;
  logic        we_gr, we_cpsr, we_spsr, chg;
  logic [3:0]  gr_waddr;
  logic [31:0] gr_wdata, rdata;
  stat_t       st;
  logic [4:0]  loc_o, loc_n;
  logic [3:0]  swap_reg;

  assign cur_mode = cpsr_r[4:0];
  assign slot     = spsr_slot(cur_mode);
  assign has_slot = slot != NO_SLOT;
  assign slot_ix  = has_slot ? slot : 3'd0;
  assign spsr_val = spsr_r[slot_ix];
  assign rd       = ins_r[15:12];
  assign rm       = ins_r[3:0];
  assign fm       = ins_r[19:16];
  assign swap_reg = 4'd8 + {1'b0, cmd.idx};
  assign raddr    = cmd.swap ? swap_reg : (req_r == REQ_READ ? ridx_r : rm);
  assign rval     = gr_r[raddr];
  assign rot_w    = {24'd0, ins_r[7:0], 24'd0, ins_r[7:0]} >> {ins_r[11:8], 1'b0};
  assign opnd     = req_r == REQ_MSR_IMM ? rot_w[31:0] : rval;
  assign mask     = {{4{fm[3]}}, 20'd0, {8{fm[0]}}} & MASK_LEGAL;
  assign cmask    = (cur_mode == MODE_USR ? (mask & MASK_FLAGS) : mask) & ~THUMB_BIT;
  assign nv_s     = (spsr_val & ~mask) | (opnd & mask);
  assign nv_c     = (cpsr_r & ~cmask) | (opnd & cmask);
  assign loc_o    = bank_loc(old_mode_r, cmd.idx);
  assign loc_n    = bank_loc(new_mode_r, cmd.idx);

  always_comb begin
    we_gr    = 1'b0;
    gr_waddr = ridx_r;
    gr_wdata = wdat_r;
    we_cpsr  = 1'b0;
    we_spsr  = 1'b0;
    chg      = 1'b0;
    rdata    = '0;
    st       = ST_DONE;
    case (req_r)
      REQ_READ: rdata = rval;
      REQ_WRITE: we_gr = 1'b1;
      REQ_MRS: begin
        gr_waddr = rd;
        if (rd == REG_PC) begin
          st = ST_PC_OPND;
        end else if (!ins_r[22]) begin
          we_gr    = 1'b1;
          gr_wdata = cpsr_r;
          rdata    = cpsr_r;
        end else if (!has_slot) begin
          st = ST_NO_SPSR;
        end else begin
          we_gr    = 1'b1;
          gr_wdata = spsr_val;
          rdata    = spsr_val;
        end
      end
      REQ_MSR_REG, REQ_MSR_IMM: begin
        if (req_r == REQ_MSR_REG && rm == REG_PC) begin
          st = ST_PC_OPND;
        end else if (ins_r[22]) begin
          if (!has_slot) begin
            st = ST_NO_SPSR;
          end else if (mask[4:0] != 5'd0 && !mode_ok(nv_s[4:0])) begin
            st = ST_BAD_MODE;
          end else begin
            we_spsr = 1'b1;
          end
        end else if (!mode_ok(nv_c[4:0])) begin
          st = ST_BAD_MODE;
        end else begin
          we_cpsr = 1'b1;
          chg     = nv_c[4:0] != cur_mode;
        end
      end
      default: ;
    endcase
  end

  assign sts.need_swap = chg;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req;
      ins_r  <= in_ins;
      ridx_r <= in_ridx;
      wdat_r <= in_wdat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) gr_r[i] <= '0;
      for (int i = 0; i < 5; i++) spsr_r[i] <= '0;
      for (int i = 0; i < NBANK; i++) bank_r[i] <= '0;
      cpsr_r     <= CPSR_RESET;
      old_mode_r <= CPSR_RESET[4:0];
      new_mode_r <= CPSR_RESET[4:0];
      rdata_r    <= '0;
      st_r       <= ST_DONE;
      chg_r      <= 1'b0;
    end else if (cmd.exec) begin
      if (we_gr) gr_r[gr_waddr] <= gr_wdata;
      if (we_spsr) spsr_r[slot_ix] <= nv_s;
      if (we_cpsr) cpsr_r <= nv_c;
      old_mode_r <= cur_mode;
      new_mode_r <= nv_c[4:0];
      rdata_r    <= rdata;
      st_r       <= st;
      chg_r      <= chg;
    end else if (cmd.swap) begin
      bank_r[loc_o]  <= rval;
      gr_r[swap_reg] <= (loc_o == loc_n) ? rval : bank_r[loc_n];
    end
  end

  assign read_data    = rdata_r;
  assign cpsr_value   = cpsr_r;
  assign status       = st_r;
  assign mode_changed = chg_r;

endmodule
`default_nettype wire
